// ===== src/fte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 flow tuple extractor package
// Shared record type, status codes and protocol constants.
// ----------------------------------------------------------------------------
package fte_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [3:0] PREFIX_BYTES = 4'd8;
	localparam logic [7:0] IP_HDR_MIN   = 8'd20;
	localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
	localparam logic [7:0] TCP_HDR_LEN  = 8'd20;
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] TOS_PRIO_MASK = 8'hf0;

	// Reset value of the minimum segment length: ceil(1944*5 / (6*8)).
	localparam int unsigned MIN_SEG_DEFAULT = (1944 * 5 + 6 * 8 - 1) / (6 * 8);

	// Configuration register indexes.
	localparam logic CFG_PREFIX_LEN  = 1'b0;
	localparam logic CFG_MIN_SEG_LEN = 1'b1;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_LEN   = 3'd1;
	localparam logic [2:0] ST_FRAGMENT  = 3'd2;
	localparam logic [2:0] ST_NOT_L4    = 3'd3;
	localparam logic [2:0] ST_UDP_SHORT = 3'd4;
	localparam logic [2:0] ST_TCP_SHORT = 3'd5;

	// One finished segment, as handed from the front end to the back end.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  proto_num;
		logic [3:0]  prio;
		logic [15:0] total_length;
		logic [63:0] source_time;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0]  ihl;
		logic        frag;
		logic        len_bad;
	} seg_rec_t;

endpackage
`default_nettype wire

// ===== src/fte_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow tuple extractor front end
// Takes segment bytes one per cycle while take is high, captures header
// fields and, on the last byte, produces a record with the length checked.
// ----------------------------------------------------------------------------
module fte_front #(
	parameter int unsigned COUNT_BITS = 17
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     take,
	input  wire  [7:0]              data_byte,
	input  wire                     last_byte,
	input  wire  [3:0]              prefix_len,
	output logic                    rec_push,
	output fte_pkg::seg_rec_t       rec
);
	import fte_pkg::*;

	localparam int unsigned CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] cnt_q;
	logic [63:0]           time_q;
	logic [31:0]           src_q, dst_q;
	logic [15:0]           tl_q;
	logic [7:0]            proto_q;
	logic [3:0]            prio_q;
	logic [13:0]           frag_q;
	logic [3:0]            ihl_q;
	logic [15:0]           sport_q, dport_q;

	logic [COUNT_BITS-1:0] pre, p, hl, off, cnt_nxt, avail;
	logic                  in_pre, hdr_zone, l4_hit;
	logic [4:0]            p_lo;
	logic [63:0]           time_d;
	logic [31:0]           src_d, dst_d;
	logic [15:0]           tl_d;
	logic [7:0]            proto_d;
	logic [3:0]            prio_d;
	logic [13:0]           frag_d;
	logic [3:0]            ihl_d;
	logic [15:0]           sport_d, dport_d;

	always_comb begin
		pre      = (prefix_len != 4'd0) ? COUNT_BITS'(PREFIX_BYTES) : '0;
		in_pre   = cnt_q < pre;
		p        = cnt_q - pre;
		p_lo     = p[4:0];
		hdr_zone = !in_pre && (p[COUNT_BITS-1:5] == '0);
		hl       = COUNT_BITS'({ihl_q, 2'b00});
		off      = p - hl;
		l4_hit   = !in_pre && (ihl_q >= 4'd5) && (p >= hl) && (off < COUNT_BITS'(4));

		time_d  = time_q;
		src_d   = src_q;
		dst_d   = dst_q;
		tl_d    = tl_q;
		proto_d = proto_q;
		prio_d  = prio_q;
		frag_d  = frag_q;
		ihl_d   = ihl_q;
		sport_d = sport_q;
		dport_d = dport_q;

		if (in_pre) begin
			time_d[{cnt_q[2:0], 3'b000} +: 8] = data_byte;
		end
		if (hdr_zone) begin
			case (p_lo)
				5'd0:  ihl_d = data_byte[3:0];
				5'd1:  prio_d = data_byte[7:4];
				5'd2:  tl_d[15:8] = data_byte;
				5'd3:  tl_d[7:0] = data_byte;
				5'd6:  frag_d[13:8] = data_byte[5:0];
				5'd7:  frag_d[7:0] = data_byte;
				5'd9:  proto_d = data_byte;
				5'd12: src_d[31:24] = data_byte;
				5'd13: src_d[23:16] = data_byte;
				5'd14: src_d[15:8] = data_byte;
				5'd15: src_d[7:0] = data_byte;
				5'd16: dst_d[31:24] = data_byte;
				5'd17: dst_d[23:16] = data_byte;
				5'd18: dst_d[15:8] = data_byte;
				5'd19: dst_d[7:0] = data_byte;
				default: ;
			endcase
		end
		if (l4_hit) begin
			case (off[1:0])
				2'd0:    sport_d[15:8] = data_byte;
				2'd1:    sport_d[7:0] = data_byte;
				2'd2:    dport_d[15:8] = data_byte;
				default: dport_d[7:0] = data_byte;
			endcase
		end

		cnt_nxt = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		avail   = (cnt_nxt >= pre) ? cnt_nxt - pre : '0;
	end

	always_comb begin
		rec_push         = take && last_byte;
		rec.src_addr     = src_d;
		rec.dst_addr     = dst_d;
		rec.proto_num    = proto_d;
		rec.prio         = prio_d;
		rec.total_length = tl_d;
		rec.source_time  = time_d;
		rec.src_port     = sport_d;
		rec.dst_port     = dport_d;
		rec.ihl          = ihl_d;
		rec.frag         = frag_d != '0;
		rec.len_bad      = (avail < COUNT_BITS'(IP_HDR_MIN))
		                || (tl_d < 16'(IP_HDR_MIN))
		                || (CMP_BITS'(tl_d) > CMP_BITS'(avail));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			time_q  <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			tl_q    <= '0;
			proto_q <= '0;
			prio_q  <= '0;
			frag_q  <= '0;
			ihl_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q   <= '0;
				time_q  <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				tl_q    <= '0;
				proto_q <= '0;
				prio_q  <= '0;
				frag_q  <= '0;
				ihl_q   <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				cnt_q   <= cnt_nxt;
				time_q  <= time_d;
				src_q   <= src_d;
				dst_q   <= dst_d;
				tl_q    <= tl_d;
				proto_q <= proto_d;
				prio_q  <= prio_d;
				frag_q  <= frag_d;
				ihl_q   <= ihl_d;
				sport_q <= sport_d;
				dport_q <= dport_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fte_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow tuple extractor record queue
// Short queue of segment records between the front and back ends.
// ----------------------------------------------------------------------------
module fte_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  fte_pkg::seg_rec_t   wr_data,
	output logic                q_full,
	output logic                q_empty,
	input  wire                 rd_en,
	output fte_pkg::seg_rec_t   rd_data
);
	import fte_pkg::*;

	localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_BITS:0] DEPTH_CNT = (PTR_BITS + 1)'(QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

	seg_rec_t            mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   cnt_q;
	logic                do_wr, do_rd;

	assign q_full  = cnt_q == DEPTH_CNT;
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/fte_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flow tuple extractor back end
// Resolves the status and padding of a segment record and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module fte_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  fte_pkg::seg_rec_t   rec,
	output logic                q_rd,
	input  wire  [9:0]          min_segment_len,
	input  wire                 pop,
	output logic                empty,
	output logic [31:0]         src_addr,
	output logic [31:0]         dst_addr,
	output logic [7:0]          proto_num,
	output logic [15:0]         src_port,
	output logic [15:0]         dst_port,
	output logic [3:0]          prio,
	output logic [15:0]         total_length,
	output logic [63:0]         source_time,
	output logic [9:0]          pad_count,
	output logic [2:0]          status
);
	import fte_pkg::*;

	logic        valid_q;
	logic [2:0]  st;
	logic [16:0] hl, seg_len;
	logic [9:0]  pad;
	logic        is_udp, is_tcp, load;

	always_comb begin
		hl     = 17'({rec.ihl, 2'b00});
		is_udp = rec.proto_num == PROTO_UDP;
		is_tcp = rec.proto_num == PROTO_TCP;
		if (rec.len_bad || rec.ihl < 4'd5) begin
			st = ST_BAD_LEN;
		end else if (rec.frag) begin
			st = ST_FRAGMENT;
		end else if (!is_udp && !is_tcp) begin
			st = ST_NOT_L4;
		end else if (is_udp && 17'(rec.total_length) < hl + 17'(UDP_HDR_LEN)) begin
			st = ST_UDP_SHORT;
		end else if (is_tcp && 17'(rec.total_length) < hl + 17'(TCP_HDR_LEN)) begin
			st = ST_TCP_SHORT;
		end else begin
			st = ST_OK;
		end
		seg_len = 17'(PREFIX_BYTES) + 17'(rec.total_length);
		if (st != ST_BAD_LEN && 17'(min_segment_len) > seg_len) begin
			pad = min_segment_len - seg_len[9:0];
		end else begin
			pad = '0;
		end
	end

	assign load  = !q_empty && (!valid_q || pop);
	assign q_rd  = load;
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			src_addr     <= rec.src_addr;
			dst_addr     <= rec.dst_addr;
			proto_num    <= rec.proto_num;
			src_port     <= (st == ST_OK) ? rec.src_port : 16'd0;
			dst_port     <= (st == ST_OK) ? rec.dst_port : 16'd0;
			prio         <= 4'((8'(rec.prio) << 4 & TOS_PRIO_MASK) >> 4);
			total_length <= rec.total_length;
			source_time  <= rec.source_time;
			pad_count    <= pad;
			status       <= st;
		end
	end

endmodule
`default_nettype wire

// ===== src/ipv4_flow_tuple_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 flow tuple extractor
// Parses link segments byte by byte and returns one flow tuple per segment.
// ----------------------------------------------------------------------------
// The block takes one segment byte per clock cycle, while full is low,
// through a push/full interface. A segment is an optional eight-byte
// little-endian source-time prefix followed by an IPv4 packet, and the byte
// marked last_byte closes it. Every byte is consumed in the cycle it is
// accepted, so a steady stream runs at one byte per cycle while full is low,
// with no gaps between segments. Once the last byte has been accepted, the
// segment's record moves through a two-entry queue to the back end, which
// works out the status and padding count; the result item is then loaded
// into the output register once that register is free, and stays there
// until it is popped. full rises only when the queue holds two finished
// segments that the output side has not yet drained, so the input
// stalls only when results are not being taken. Ports read as zero unless the
// status is OK, and the padding count is zero for a bad length or header
// length. The configuration channel is always ready: index 0 selects the
// prefix length (any nonzero value means an eight-byte prefix) and index 1 the
// minimum segment length; both should be written only while the block is
// idle. COUNT_BITS sets the width of the saturating byte counter.
// ----------------------------------------------------------------------------
module ipv4_flow_tuple_extractor #(
	parameter int unsigned COUNT_BITS = 17
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        empty,
	input  wire         pop,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [7:0]  proto_num,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [3:0]  prio,
	output logic [15:0] total_length,
	output logic [63:0] source_time,
	output logic [9:0]  pad_count,
	output logic [2:0]  status,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [9:0]  cfg_data
);
	import fte_pkg::*;

	logic [3:0] prefix_len_q;
	logic [9:0] min_seg_len_q;
	logic       take;
	logic       rec_push;
	seg_rec_t   front_rec;
	seg_rec_t   back_rec;
	logic       q_full, q_empty, q_rd;

	// Configuration registers; the channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_len_q  <= PREFIX_BYTES;
			min_seg_len_q <= 10'(MIN_SEG_DEFAULT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PREFIX_LEN:  prefix_len_q <= cfg_data[3:0];
				CFG_MIN_SEG_LEN: min_seg_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A byte is accepted whenever the record queue has room.
	assign full = q_full;
	assign take = push && !q_full;

	fte_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.prefix_len (prefix_len_q),
		.rec_push   (rec_push),
		.rec        (front_rec)
	);

	fte_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (front_rec),
		.q_full  (q_full),
		.q_empty (q_empty),
		.rd_en   (q_rd),
		.rd_data (back_rec)
	);

	fte_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.rec             (back_rec),
		.q_rd            (q_rd),
		.min_segment_len (min_seg_len_q),
		.pop             (pop),
		.empty           (empty),
		.src_addr        (src_addr),
		.dst_addr        (dst_addr),
		.proto_num       (proto_num),
		.src_port        (src_port),
		.dst_port        (dst_port),
		.prio            (prio),
		.total_length    (total_length),
		.source_time     (source_time),
		.pad_count       (pad_count),
		.status          (status)
	);

endmodule
`default_nettype wire

// ===== tb/tb_ipv4_flow_tuple_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IPv4 flow tuple extractor
// Streams link segments into the block a byte at a time, predicts every flow
// tuple alongside it and checks each popped result field by field.
// ----------------------------------------------------------------------------
// Segments are built from packet descriptions: mostly well-formed UDP and TCP
// packets with random content and header lengths, mixed with fragments,
// foreign protocols, short layer-4 headers, bad header lengths, truncated
// buffers, tiny segments and pure noise. A short directed run covers the
// corner cases first, and the run then walks through several prefix and
// minimum-length settings, one of them opening with a long segment whose
// total length lies far beyond the buffer. Both the byte source and the
// result sink stall at random, except in one phase where they run flat out.
// ----------------------------------------------------------------------------
module tb_ipv4_flow_tuple_extractor;
	import fte_pkg::*;

	localparam int COUNT_BITS = 17;
	localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int IDLE_PCT = 28;
	localparam int RANDOM_BYTES_PER_PHASE = 150;
	// Settling time that drain() allows once all bytes and results are through.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_PRINTED = 50;

	// One byte on the input side of the block.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	// One flow tuple as it appears on the result ports.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  proto_num;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [3:0]  prio;
		logic [15:0] total_length;
		logic [63:0] source_time;
		logic [9:0]  pad_count;
		logic [2:0]  status;
	} tuple_t;

	// What the parser has gathered so far from the segment in progress.
	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [63:0]           stamp;
		logic [3:0]            ihl;
		logic [7:0]            tos;
		logic [7:0]            proto;
		logic [15:0]           tlen;
		logic [15:0]           frag;
		logic [63:0]           addrs;
		logic [31:0]           ports;
	} seg_track_t;

	// Description of one segment to be sent. ip_len counts the bytes after the
	// prefix; a negative value cuts the segment off inside the prefix. A raw
	// segment carries random bytes only.
	typedef struct {
		logic [63:0] stamp;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [7:0]  tos;
		logic [7:0]  proto;
		logic [15:0] tlen;
		logic [15:0] frag;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		int          ip_len;
		bit          raw;
	} pkt_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [7:0]  proto_num;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [3:0]  prio;
	logic [15:0] total_length;
	logic [63:0] source_time;
	logic [9:0]  pad_count;
	logic [2:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_PREFIX_LEN;
	logic [9:0]  cfg_data = '0;

	// Our own copy of the configuration, updated when a write is taken.
	logic [3:0] cfg_prefix = PREFIX_BYTES;
	logic [9:0] cfg_min_seg = 10'(MIN_SEG_DEFAULT);

	seg_track_t  trk = '0;
	wire_byte_t  wire_bytes[$];
	tuple_t      tuples_due[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	// When set, neither side idles: this gives the long stretch at full rate.
	bit          steady = 1'b0;

	ipv4_flow_tuple_extractor #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.src_addr(src_addr),
		.dst_addr(dst_addr),
		.proto_num(proto_num),
		.src_port(src_port),
		.dst_port(dst_port),
		.prio(prio),
		.total_length(total_length),
		.source_time(source_time),
		.pad_count(pad_count),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Reset is held low from the start and released at a rising edge.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("ipv4_flow_tuple_extractor verification failed");
		$finish;
	end

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Follows one accepted byte through the segment, mirroring the capture
	// rules of the block. On the last byte the packet is judged, the flow
	// tuple is queued as the next expected result and the segment state is
	// cleared.
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		int unsigned pre;
		int unsigned pos;
		int unsigned hl;
		int unsigned avail;
		int unsigned tl;
		int unsigned seg_len;
		logic [2:0]  st;
		tuple_t      t;

		pre = (cfg_prefix != 0) ? PREFIX_BYTES : 0;
		// The header length in force is the one captured before this byte.
		hl = trk.ihl * 4;
		if (trk.count < pre) begin
			trk.stamp[8 * trk.count +: 8] = b;
		end else begin
			pos = trk.count - pre;
			if (pos == 0) begin
				trk.ihl = b[3:0];
			end else if (pos == 1) begin
				trk.tos = b;
			end else if (pos == 2 || pos == 3) begin
				trk.tlen[8 * (3 - pos) +: 8] = b;
			end else if (pos == 6 || pos == 7) begin
				trk.frag[8 * (7 - pos) +: 8] = b;
			end else if (pos == 9) begin
				trk.proto = b;
			end else if (pos >= 12 && pos <= 19) begin
				trk.addrs[8 * (19 - pos) +: 8] = b;
			end
			// The ports sit just after the options, wherever the IHL puts them.
			if (hl >= IP_HDR_MIN && pos >= hl && pos < hl + 4) begin
				trk.ports[8 * (3 - (pos - hl)) +: 8] = b;
			end
		end
		if (trk.count != COUNT_MAX) begin
			trk.count++;
		end
		if (!last) begin
			return;
		end

		avail = (trk.count >= pre) ? trk.count - pre : 0;
		tl = trk.tlen;
		hl = trk.ihl * 4;
		// The checks are taken in a fixed order; the first one that trips wins.
		if (avail < IP_HDR_MIN || tl < IP_HDR_MIN || tl > avail) begin
			st = ST_BAD_LEN;
		end else if (hl < IP_HDR_MIN) begin
			st = ST_BAD_LEN;
		end else if (trk.frag[13:0] != 0) begin
			st = ST_FRAGMENT;
		end else if (trk.proto != PROTO_UDP && trk.proto != PROTO_TCP) begin
			st = ST_NOT_L4;
		end else if (trk.proto == PROTO_UDP && tl < hl + UDP_HDR_LEN) begin
			st = ST_UDP_SHORT;
		end else if (trk.proto == PROTO_TCP && tl < hl + TCP_HDR_LEN) begin
			st = ST_TCP_SHORT;
		end else begin
			st = ST_OK;
		end

		seg_len = PREFIX_BYTES + tl;
		t.src_addr = trk.addrs[63:32];
		t.dst_addr = trk.addrs[31:0];
		t.proto_num = trk.proto;
		t.src_port = (st == ST_OK) ? trk.ports[31:16] : 16'h0000;
		t.dst_port = (st == ST_OK) ? trk.ports[15:0] : 16'h0000;
		t.prio = trk.tos[7:4];
		t.total_length = trk.tlen;
		t.source_time = trk.stamp;
		t.pad_count = (st != ST_BAD_LEN && cfg_min_seg > seg_len) ?
			cfg_min_seg - seg_len : 0;
		t.status = st;
		tuples_due.push_back(t);
		trk = '0;
	endfunction

	// A minimal well-formed packet with random addresses, ports and stamp.
	function automatic pkt_t base_packet(input logic [7:0] proto);
		pkt_t p;

		p.stamp = {$urandom, $urandom};
		p.ver = $urandom;
		p.ihl = 4'd5;
		p.tos = $urandom;
		p.proto = proto;
		p.tlen = IP_HDR_MIN + ((proto == PROTO_UDP) ? UDP_HDR_LEN : TCP_HDR_LEN);
		p.frag = '0;
		p.src = $urandom;
		p.dst = $urandom;
		p.sport = $urandom;
		p.dport = $urandom;
		p.ip_len = p.tlen;
		p.raw = 1'b0;
		return p;
	endfunction

	// Mostly sound UDP or TCP packets; about three in ten are spoilt on
	// purpose so that every status turns up.
	function automatic pkt_t random_packet();
		pkt_t p;
		int   pre;
		int   need;
		int   top;

		pre = (cfg_prefix != 0) ? PREFIX_BYTES : 0;
		p = base_packet($urandom_range(1) ? PROTO_UDP : PROTO_TCP);
		if ($urandom_range(3) == 0) begin
			p.ihl = $urandom_range(6, 15);
		end
		need = (p.proto == PROTO_UDP) ? UDP_HDR_LEN : TCP_HDR_LEN;
		p.tlen = p.ihl * 4 + need + $urandom_range(0, 24);
		p.ip_len = p.tlen + (($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
		// The reserved and don't-fragment bits must not matter.
		p.frag = $urandom_range(3) << 14;
		if ($urandom_range(99) < 30) begin
			case ($urandom_range(7))
				0: p.frag[13:0] = $urandom_range(1, 16383);
				1: begin
					p.proto = $urandom;
					if (p.proto == PROTO_UDP || p.proto == PROTO_TCP) begin
						p.proto = 8'd1;
					end
				end
				2: begin
					p.tlen = p.ihl * 4 + $urandom_range(0, need - 1);
					p.ip_len = p.tlen;
				end
				3: p.ihl = $urandom_range(0, 4);
				4: p.tlen = $urandom_range(0, 19);
				5: begin
					if ($urandom_range(1)) begin
						p.tlen = $urandom_range(256, 65535);
					end
					top = (p.tlen > 80) ? 80 : p.tlen - 1;
					p.ip_len = $urandom_range(20, top);
				end
				6: p.ip_len = $urandom_range(1, pre + 19) - pre;
				default: begin
					p.raw = 1'b1;
					p.ip_len = $urandom_range(1, 64);
				end
			endcase
		end
		return p;
	endfunction

	// Lays a packet out as wire bytes and appends them to the send queue.
	// Bytes that no field claims are random. Returns the segment length.
	function automatic int queue_packet(input pkt_t p);
		int          pre;
		int          total;
		int          hl;
		int          pos;
		logic [7:0]  b;
		logic [63:0] addrs;
		logic [31:0] ports;
		wire_byte_t  wb;

		pre = (cfg_prefix != 0) ? PREFIX_BYTES : 0;
		total = pre + p.ip_len;
		if (total < 1) begin
			total = 1;
		end
		hl = p.ihl * 4;
		addrs = {p.src, p.dst};
		ports = {p.sport, p.dport};
		for (int i = 0; i < total; i++) begin
			b = $urandom;
			if (!p.raw) begin
				if (i < pre) begin
					b = p.stamp[8 * i +: 8];
				end else begin
					pos = i - pre;
					if (pos == 0) begin
						b = {p.ver, p.ihl};
					end else if (pos == 1) begin
						b = p.tos;
					end else if (pos == 2 || pos == 3) begin
						b = p.tlen[8 * (3 - pos) +: 8];
					end else if (pos == 6 || pos == 7) begin
						b = p.frag[8 * (7 - pos) +: 8];
					end else if (pos == 9) begin
						b = p.proto;
					end else if (pos >= 12 && pos <= 19) begin
						b = addrs[8 * (19 - pos) +: 8];
					end
					if (hl >= IP_HDR_MIN && pos >= hl && pos < hl + 4) begin
						b = ports[8 * (3 - (pos - hl)) +: 8];
					end
				end
			end
			wb.data = b;
			wb.last = (i == total - 1);
			wire_bytes.push_back(wb);
		end
		return total;
	endfunction

	task automatic fill_random(input int n);
		int queued;

		queued = 0;
		while (queued < n) begin
			queued += queue_packet(random_packet());
		end
	endtask

	// Writes one register and, once the block has taken it, our own copy.
	task automatic write_reg(input logic idx, input logic [9:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PREFIX_LEN) begin
			cfg_prefix = val[3:0];
		end else begin
			cfg_min_seg = val;
		end
	endtask

	// Waits until every byte has gone in and every tuple has come out, then
	// gives the block a few more cycles to settle.
	task automatic drain();
		do begin
			@(posedge clk);
		end while (wire_bytes.size() != 0 || push || tuples_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Byte source. An item is taken at an edge where push is high and full is
	// low; only then, or when nothing is offered, is the next byte put up.
	// Values read here are those from just before the edge.
	always @(posedge clk) begin : byte_source
		wire_byte_t item;

		if (arst_n) begin
			if (push && !full) begin
				parse_byte(data_byte, last_byte);
			end
			if (!push || !full) begin
				if (wire_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					item = wire_bytes.pop_front();
					push <= 1'b1;
					data_byte <= item.data;
					last_byte <= item.last;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Result sink. A tuple popped at this edge is compared with the oldest
	// one predicted; pop itself stalls at random.
	always @(posedge clk) begin : tuple_sink
		tuple_t want;

		if (arst_n) begin
			if (pop && !empty) begin
				if (tuples_due.size() == 0) begin
					report_error("result popped while none was expected");
				end else begin
					want = tuples_due.pop_front();
					check_field("src_addr", src_addr, want.src_addr);
					check_field("dst_addr", dst_addr, want.dst_addr);
					check_field("proto_num", proto_num, want.proto_num);
					check_field("src_port", src_port, want.src_port);
					check_field("dst_port", dst_port, want.dst_port);
					check_field("prio", prio, want.prio);
					check_field("total_length", total_length, want.total_length);
					check_field("source_time", source_time, want.source_time);
					check_field("pad_count", pad_count, want.pad_count);
					check_field("status", status, want.status);
				end
			end
			pop <= steady || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin : stimulus
		pkt_t p;

		wait (arst_n);

		// Directed segments under the reset settings: eight-byte prefix and
		// the default minimum length of 203 bytes.
		// Smallest sound UDP packet, with all-ones and all-zeros fields.
		p = base_packet(PROTO_UDP);
		p.stamp = '1;
		p.tos = 8'hff;
		p.src = '1;
		p.dst = '0;
		p.sport = '1;
		p.dport = '0;
		void'(queue_packet(p));
		// TCP behind the longest header, fields the other way round.
		p = base_packet(PROTO_TCP);
		p.stamp = '0;
		p.tos = 8'h00;
		p.src = '0;
		p.dst = '1;
		p.sport = '0;
		p.dport = '1;
		p.ihl = 4'd15;
		p.tlen = 16'd80;
		p.ip_len = 80;
		void'(queue_packet(p));
		// Don't-fragment and the reserved bit alone leave the packet whole.
		p = base_packet(PROTO_UDP);
		p.frag = 16'hc000;
		void'(queue_packet(p));
		// More-fragments set, then a bare fragment offset.
		p = base_packet(PROTO_UDP);
		p.frag = 16'h2000;
		void'(queue_packet(p));
		p = base_packet(PROTO_TCP);
		p.frag = 16'h0001;
		void'(queue_packet(p));
		// Protocols other than UDP and TCP.
		p = base_packet(8'd1);
		void'(queue_packet(p));
		p = base_packet(8'hff);
		void'(queue_packet(p));
		// Layer-4 header one byte short, for UDP and for TCP.
		p = base_packet(PROTO_UDP);
		p.tlen = 16'd27;
		p.ip_len = 27;
		void'(queue_packet(p));
		p = base_packet(PROTO_TCP);
		p.tlen = 16'd39;
		p.ip_len = 39;
		void'(queue_packet(p));
		// Header length below five words.
		p = base_packet(PROTO_UDP);
		p.ihl = 4'd4;
		void'(queue_packet(p));
		// Total length below the IPv4 header size.
		p = base_packet(PROTO_UDP);
		p.tlen = 16'd19;
		p.ip_len = 28;
		void'(queue_packet(p));
		// Total length beyond what the buffer holds, modestly and wildly.
		p = base_packet(PROTO_TCP);
		p.ip_len = 30;
		void'(queue_packet(p));
		p = base_packet(PROTO_UDP);
		p.tlen = 16'hffff;
		p.ip_len = 40;
		void'(queue_packet(p));
		// Only 19 bytes after the prefix.
		p = base_packet(PROTO_UDP);
		p.tlen = 16'd20;
		p.ip_len = 19;
		void'(queue_packet(p));
		// Segment that ends inside the prefix.
		p = base_packet(PROTO_UDP);
		p.ip_len = -5;
		void'(queue_packet(p));
		// Trailing bytes well past the fields of interest.
		p = base_packet(PROTO_TCP);
		p.ip_len = p.tlen + 30;
		void'(queue_packet(p));
		// Options in the header and a total length that fills the buffer.
		p = base_packet(PROTO_UDP);
		p.ihl = 4'd6;
		p.tlen = 16'd32;
		p.ip_len = 32;
		void'(queue_packet(p));
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();

		// No prefix and no padding.
		write_reg(CFG_PREFIX_LEN, 10'd0);
		write_reg(CFG_MIN_SEG_LEN, 10'd0);
		// A lone byte is a segment of its own.
		p = base_packet(PROTO_UDP);
		p.ip_len = 1;
		void'(queue_packet(p));
		p = base_packet(PROTO_UDP);
		void'(queue_packet(p));
		p = base_packet(PROTO_TCP);
		p.sport = '1;
		p.dport = '1;
		void'(queue_packet(p));
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();

		// The widest prefix code still means eight bytes; largest padding.
		write_reg(CFG_PREFIX_LEN, 10'd15);
		write_reg(CFG_MIN_SEG_LEN, 10'd1023);
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();

		write_reg(CFG_PREFIX_LEN, 10'd1);
		write_reg(CFG_MIN_SEG_LEN, 10'($urandom_range(1, 1022)));
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();

		// Full rate on both sides. The first segment is a long one whose
		// total length lies far beyond what the buffer holds.
		steady = 1'b1;
		write_reg(CFG_PREFIX_LEN, 10'd0);
		write_reg(CFG_MIN_SEG_LEN, 10'd1023);
		p = base_packet(PROTO_UDP);
		p.tlen = 16'hffff;
		p.ip_len = 120;
		void'(queue_packet(p));
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();
		steady = 1'b0;

		// Back to the reset settings.
		write_reg(CFG_PREFIX_LEN, 10'(PREFIX_BYTES));
		write_reg(CFG_MIN_SEG_LEN, 10'(MIN_SEG_DEFAULT));
		fill_random(RANDOM_BYTES_PER_PHASE);
		drain();

		if (error_count == 0) begin
			$display("ipv4_flow_tuple_extractor verification clean");
		end else begin
			$display("ipv4_flow_tuple_extractor verification failed");
		end
		$finish;
	end

endmodule
